// ===== design/assert_macros.svh =====
// Assertion macros used by the scheduler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/llf_pkg.sv =====
// Types and constants of the least-laxity-first scheduler.
package llf_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_BITS  = 4;
  localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);
  localparam int CFG_BITS  = 5;
  localparam int ADDR_BITS = $clog2(MAX_TASKS);
  localparam int LAX_BITS  = TIME_BITS + 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic signed [LAX_BITS-1:0] lax_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic                req_type;
    logic [IDX_BITS-1:0] task_index;
    time_t               release_time;
    time_t               deadline;
    time_t               exec_time;
  } req_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] run_index;
    logic                idle;
    logic                finished;
  } result_t;

  typedef struct packed {
    time_t release_time;
    time_t deadline;
    time_t remaining;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== design/llf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module llf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/least_laxity_first_scheduler_core.sv =====
// Top level of the least-laxity-first scheduler: task table, scan and update.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------
//  request  | start, busy              | req (load entry or tick)
//  result   | done (one-cycle strobe)  | result (run_index, idle, finished)
//  config   | cfg_valid, cfg_ready     | cfg_data (active_count)
//
// A load writes the task table directly.
// A tick reads min(active_count, 16) table entries from the RAM one entry per cycle,
// then the winner is written back and the result strobed.
// The next request is taken in the same cycle that done is high.
// After reset the tick counter and active_count are zero; the table is undefined.
// The receiver cannot stall the result.
`include "assert_macros.svh"

module least_laxity_first_scheduler_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  llf_pkg::req_t                 req,
  output logic                          done,
  output llf_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [llf_pkg::CFG_BITS-1:0]  cfg_data
);

  import llf_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [CFG_BITS-1:0]   active_count;
  time_t                 current_tick;
  logic [ADDR_BITS-1:0]  scan_idx;
  logic                  found;
  logic [ADDR_BITS-1:0]  best_idx;
  lax_t                  best_lax;
  entry_t                best_entry;

  logic                  accept;
  logic [CNT_BITS-1:0]   scan_len;
  logic                  last;
  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_wr_addr;
  entry_t                ram_wr_data;
  logic                  ram_re;
  logic [ADDR_BITS-1:0]  ram_rd_addr;
  entry_t                ram_rd_data;
  logic                  cand_ready;
  lax_t                  cand_lax;
  logic                  cand_wins;
  time_t                 best_rem_next;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Entries at or beyond the table size are not scanned.
  assign scan_len = (CNT_BITS'(active_count) > CNT_BITS'(MAX_TASKS)) ?
                    CNT_BITS'(MAX_TASKS) : CNT_BITS'(active_count);
  assign last     = (CNT_BITS'(scan_idx) + CNT_BITS'(1)) == scan_len;

  // Candidate evaluation on the entry whose read data arrives this cycle.
  assign cand_ready = (ram_rd_data.release_time <= current_tick) &&
                      (ram_rd_data.remaining != '0);
  assign cand_lax   = lax_t'({2'b00, ram_rd_data.deadline}) -
                      lax_t'({2'b00, ram_rd_data.remaining}) -
                      lax_t'({2'b00, current_tick});
  assign cand_wins  = cand_ready && (!found || (cand_lax < best_lax));

  assign best_rem_next = best_entry.remaining - time_t'(1);

  llf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .re      (ram_re),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_wr_addr = req.task_index[ADDR_BITS-1:0];
    ram_wr_data = '{release_time: req.release_time,
                    deadline:     req.deadline,
                    remaining:    req.exec_time};
    ram_re      = 1'b0;
    ram_rd_addr = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_LOAD) begin
            ram_we = (CNT_BITS'(req.task_index) < CNT_BITS'(MAX_TASKS));
          end else if (scan_len == '0) begin
            state_next = ST_DONE;
          end else begin
            ram_re     = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_re      = !last;
        ram_rd_addr = scan_idx + ADDR_BITS'(1);
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Write the winner back with one tick of work taken off.
        ram_we      = found;
        ram_wr_addr = best_idx;
        ram_wr_data = '{release_time: best_entry.release_time,
                        deadline:     best_entry.deadline,
                        remaining:    best_rem_next};
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_count <= '0;
      current_tick <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        active_count <= cfg_data;
      end
      if (state == ST_IDLE && accept) begin
        found    <= 1'b0;
        scan_idx <= '0;
      end
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + ADDR_BITS'(1);
        if (cand_wins) begin
          found      <= 1'b1;
          best_idx   <= scan_idx;
          best_lax   <= cand_lax;
          best_entry <= ram_rd_data;
        end
      end
      if (state == ST_DONE && current_tick != '1) begin
        current_tick <= current_tick + time_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      result.run_index <= found ? IDX_BITS'(best_idx) : '0;
      result.idle      <= !found;
      result.finished  <= found && (best_rem_next == '0);
    end
  end

  `ASSERT_CLK(a_done_not_busy, done |-> !busy, "result strobed while busy")
  `ASSERT_NEVER(a_ram_overlap, ram_we && ram_re, "table read and write in one cycle")
  `ASSERT_CLK(a_tick_busy, (accept && req.req_type == REQ_TICK) |=> busy,
              "tick accepted but block not busy")
  `ASSERT_CLK(a_idle_clean, (done && result.idle) |-> (result.run_index == '0 && !result.finished),
              "idle result carries a task")

endmodule

// ===== tb/least_laxity_first_scheduler_core_test.sv =====
// Self-checking testbench for the least-laxity-first scheduler core.
module least_laxity_first_scheduler_core_test;
  import llf_pkg::*;

  localparam int SETTLE_CYCLES = MAX_TASKS + 6;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int TICK_MAX      = (1 << TIME_BITS) - 1;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 46;

  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_CONFIG,
    ACT_DRAIN
  } action_t;

  typedef struct {
    action_t             kind;
    req_t                word;
    logic [CFG_BITS-1:0] count;
    bit                  gaps_on;
  } action_item_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                start     = 1'b0;
  logic                busy;
  req_t                req       = '0;
  logic                done;
  result_t             result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data  = '0;

  least_laxity_first_scheduler_core DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  // Scheduler state as the testbench sees it.
  time_t               release_tab   [MAX_TASKS];
  time_t               deadline_tab  [MAX_TASKS];
  time_t               remaining_tab [MAX_TASKS];
  time_t               now_tick   = '0;
  logic [CFG_BITS-1:0] slot_count = '0;
  result_t             expected_runs [$];

  // Planned stimulus and the tick count that the plan will have reached.
  action_item_t pending_q [$];
  time_t        plan_now  = '0;
  bit           plan_gaps = 1'b1;

  bit took_req     = 1'b0;
  bit took_cfg     = 1'b0;
  int quiet_cycles = 0;
  int cycle_count  = 0;
  int fail_count   = 0;

  function automatic void store_task_entry(req_t w);
    release_tab[w.task_index]   = w.release_time;
    deadline_tab[w.task_index]  = w.deadline;
    remaining_tab[w.task_index] = w.exec_time;
  endfunction

  function automatic result_t run_llf_tick();
    result_t r;
    int      scan_n;
    int      best;
    int      lax;
    int      best_lax;
    bit      found;
    r        = '0;
    found    = 1'b0;
    best     = 0;
    best_lax = 0;
    scan_n   = (slot_count > MAX_TASKS) ? MAX_TASKS : int'(slot_count);
    for (int i = 0; i < scan_n; i++) begin
      if (release_tab[i] <= now_tick && remaining_tab[i] != '0) begin
        lax = int'(deadline_tab[i]) - int'(remaining_tab[i]) - int'(now_tick);
        // Strict compare keeps the lowest index on a tie.
        if (!found || lax < best_lax) begin
          found    = 1'b1;
          best     = i;
          best_lax = lax;
        end
      end
    end
    if (found) begin
      remaining_tab[best] = remaining_tab[best] - 1'b1;
      r.run_index         = best[IDX_BITS-1:0];
      r.finished          = (remaining_tab[best] == '0);
    end
    r.idle = !found;
    if (now_tick != time_t'(TICK_MAX)) now_tick = now_tick + 1'b1;
    return r;
  endfunction

  function automatic void plan_word(req_t w);
    action_item_t a;
    a.kind    = ACT_WORD;
    a.word    = w;
    a.count   = '0;
    a.gaps_on = plan_gaps;
    pending_q.push_back(a);
  endfunction

  function automatic void plan_action(action_t kind, int count);
    action_item_t a;
    a.kind    = kind;
    a.word    = '0;
    a.count   = count[CFG_BITS-1:0];
    a.gaps_on = plan_gaps;
    pending_q.push_back(a);
  endfunction

  function automatic void plan_load(int idx, int rel, int dl, int ex);
    req_t w;
    w              = '0;
    w.req_type     = REQ_LOAD;
    w.task_index   = idx[IDX_BITS-1:0];
    w.release_time = rel[TIME_BITS-1:0];
    w.deadline     = dl[TIME_BITS-1:0];
    w.exec_time    = ex[TIME_BITS-1:0];
    plan_word(w);
  endfunction

  function automatic void plan_tick();
    req_t w;
    // The payload fields of a tick are don't-care, so they carry random bits.
    w.req_type     = REQ_TICK;
    w.task_index   = IDX_BITS'($urandom);
    w.release_time = time_t'($urandom);
    w.deadline     = time_t'($urandom);
    w.exec_time    = time_t'($urandom);
    plan_word(w);
    if (plan_now != time_t'(TICK_MAX)) plan_now = plan_now + 1'b1;
  endfunction

  function automatic int near_plan(int lo, int hi);
    int v;
    v = int'(plan_now) + lo + int'($urandom_range(hi - lo));
    if (v < 0) v = 0;
    if (v > TICK_MAX) v = TICK_MAX;
    return v;
  endfunction

  function automatic int pick_release();
    case ($urandom_range(9))
      0:       return 0;
      1:       return TICK_MAX;
      2:       return $urandom_range(TICK_MAX);
      default: return near_plan(-4, 2);
    endcase
  endfunction

  function automatic int pick_deadline();
    case ($urandom_range(9))
      0:       return 0;
      1:       return TICK_MAX;
      default: return near_plan(0, 40);
    endcase
  endfunction

  function automatic int pick_exec();
    case ($urandom_range(19))
      0:       return 0;
      1:       return TICK_MAX;
      2:       return $urandom_range(40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  initial begin : reset_gen
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(negedge clk) begin : driver
    logic                next_start;
    logic                next_cfg;
    req_t                next_req;
    logic [CFG_BITS-1:0] next_data;
    action_item_t        head;
    bit                  settled;
    next_start = start;
    next_cfg   = cfg_valid;
    next_req   = req;
    next_data  = cfg_data;
    settled    = (expected_runs.size() == 0) && (quiet_cycles >= SETTLE_CYCLES);
    if (!rst) begin
      if (took_req) next_start = 1'b0;
      if (took_cfg) next_cfg = 1'b0;
      if (!next_start && !next_cfg && pending_q.size() != 0) begin
        head = pending_q[0];
        if (!head.gaps_on || $urandom_range(99) >= 35) begin
          case (head.kind)
            ACT_WORD: begin
              next_start = 1'b1;
              next_req   = head.word;
              void'(pending_q.pop_front());
            end
            ACT_CONFIG: begin
              if (settled) begin
                next_cfg  = 1'b1;
                next_data = head.count;
                void'(pending_q.pop_front());
              end
            end
            default: begin
              if (settled) void'(pending_q.pop_front());
            end
          endcase
        end
      end
    end
    start     <= next_start;
    req       <= next_req;
    cfg_valid <= next_cfg;
    cfg_data  <= next_data;
  end

  always @(posedge clk) begin : monitor
    result_t want;
    took_req = 1'b0;
    took_cfg = 1'b0;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (expected_runs.size() == 0) begin
          $error("result with no tick pending: run_index %0d idle %0b finished %0b",
                 result.run_index, result.idle, result.finished);
          fail_count++;
        end else begin
          want = expected_runs.pop_front();
          if (result.run_index !== want.run_index) begin
            $error("run_index: expected %0d, got %0d", want.run_index, result.run_index);
            fail_count++;
          end
          if (result.idle !== want.idle) begin
            $error("idle: expected %0b, got %0b", want.idle, result.idle);
            fail_count++;
          end
          if (result.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, result.finished);
            fail_count++;
          end
        end
      end
      // A tick taken in the same cycle as done belongs after that result.
      if (start && !busy) begin
        took_req = 1'b1;
        if (req.req_type == REQ_TICK) expected_runs.push_back(run_llf_tick());
        else store_task_entry(req);
      end
      if (cfg_valid && cfg_ready) begin
        took_cfg   = 1'b1;
        slot_count = cfg_data;
      end
      if (done || took_req || took_cfg || expected_runs.size() != 0) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : stimulus
    int counts [PHASES];
    int pick;
    counts    = '{16, 1, 31, 0, 9, 17, 16, 3};
    counts[7] = $urandom_range(2, 15);

    // Directed part: an idle tick at reset, then a small table with a tie,
    // an unreleased task, a zero-length task and tasks that finish.
    plan_tick();
    plan_action(ACT_CONFIG, 4);
    plan_load(0, 0, TICK_MAX, 3);
    plan_load(1, 0, 8, 2);
    plan_load(2, 0, 8, 2);
    plan_load(3, TICK_MAX, 0, 1);
    plan_load(15, 0, 0, 0);
    repeat (9) plan_tick();
    plan_load(3, 0, 0, 1);
    plan_tick();

    // Fill the whole table so that any active_count is safe to scan.
    for (int i = 0; i < MAX_TASKS; i++) plan_load(i, pick_release(), pick_deadline(), pick_exec());

    for (int ph = 0; ph < PHASES; ph++) begin
      plan_gaps = (ph != 5);
      plan_action(ACT_CONFIG, counts[ph]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == PHASE_ITEMS / 2) plan_action(ACT_DRAIN, 0);
        pick = $urandom_range(99);
        if (pick < 12) begin
          plan_load($urandom_range(MAX_TASKS - 1), $urandom, $urandom, $urandom);
        end else if (pick < 40) begin
          plan_load($urandom_range(MAX_TASKS - 1), pick_release(), pick_deadline(),
                    pick_exec());
        end else begin
          plan_tick();
        end
      end
    end

    // Reload the whole table and schedule over all of it once more.
    plan_gaps = 1'b1;
    plan_action(ACT_CONFIG, MAX_TASKS);
    for (int i = 0; i < MAX_TASKS; i++) plan_load(i, pick_release(), pick_deadline(), pick_exec());
    repeat (30) plan_tick();

    while (pending_q.size() != 0 || start || cfg_valid) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/llf_pkg.sv
design/llf_ram.sv
design/least_laxity_first_scheduler_core.sv
tb/least_laxity_first_scheduler_core_test.sv
